### src/gorm_pkg.sv
// Shared types, constants and the critical-value table for the Grubbs outlier block.
package gorm_pkg;

    // Fixed field and arithmetic widths
    localparam int X_W       = 32;   // sample width after sign extension
    localparam int Q_W       = 68;   // sum of squares of up to 20 samples
    localparam int MUL_LW    = 32;   // limb width of the shared multiplier
    localparam int MUL_AW    = 96;   // multiplicand: three limbs
    localparam int MUL_BW    = 64;   // multiplier: two limbs
    localparam int MUL_PW    = 128;  // product kept modulo 2^128
    localparam int G_W       = 14;   // Q2.12 critical value
    localparam int GSQ_W     = 28;
    localparam int CRIT_COLS = 18;
    localparam int CONF_W    = 2;
    localparam int MIN_SAMPLES = 3;
    localparam int LHS_SHIFT = 24;

    localparam logic [CONF_W-1:0] CONF_RESET = 2'd3;

    // Critical values G(n) in Q2.12, rows 99/95/90/80 percent, columns n = 3..20
    localparam logic [G_W-1:0] CRIT_Q12 [4][CRIT_COLS] = '{
        '{14'd4731, 14'd6111, 14'd7164, 14'd7963, 14'd8589, 14'd9093, 14'd9515, 14'd9871,
          14'd10179, 14'd10445, 14'd10678, 14'd10891, 14'd11080, 14'd11252, 14'd11407,
          14'd11555, 14'd11690, 14'd11813},
        '{14'd4723, 14'd5992, 14'd6849, 14'd7463, 14'd7938, 14'd8323, 14'd8643, 14'd8913,
          14'd9150, 14'd9359, 14'd9548, 14'd9712, 14'd9867, 14'd10007, 14'd10138,
          14'd10244, 14'd10371, 14'd10473},
        '{14'd4702, 14'd5837, 14'd6562, 14'd7082, 14'd7487, 14'd7819, 14'd8098, 14'd8339,
          14'd8552, 14'd8741, 14'd8909, 14'd9064, 14'd9204, 14'd9335, 14'd9458,
          14'd9564, 14'd9671, 14'd9769},
        '{14'd4702, 14'd4735, 14'd5128, 14'd5444, 14'd5849, 14'd6181, 14'd6459, 14'd6701,
          14'd6914, 14'd7102, 14'd7270, 14'd7425, 14'd7565, 14'd7696, 14'd7819,
          14'd7926, 14'd8032, 14'd8131}
    };

    function automatic logic [G_W-1:0] crit_q12(input logic [CONF_W-1:0] row,
                                                input logic [4:0] col);
        return CRIT_Q12[row][col];
    endfunction

    // Request payloads
    typedef struct packed {
        logic signed [X_W-1:0] sample;
        logic                  last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [X_W-1:0] average;
        logic                  ok;
    } t_out_item;

    // Operand selection for the shared multiplier
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_QN   = 3'd1,   // q * n
        OP_SS   = 3'd2,   // s * s, spread = n*q - s^2
        OP_SPN  = 3'd3,   // spread * n
        OP_THR  = 3'd4,   // spread * n * G^2
        OP_DD   = 3'd5,   // d * d
        OP_LHS  = 3'd6    // d^2 * (n-1), then compare
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    set_clr;
        logic    sum_clr;
        logic    sum_feed;
        logic    rd_sample;
        logic    diff_load;
        logic    g2_load;
        logic    hit_clr;
        logic    mul_go;
        t_mul_op mul_op;
        logic    div_go;
        logic    drop;
        logic    out_load;
        logic    out_ok;
    } t_cmd;

    typedef struct packed {
        logic set_bad;
        logic idx_lt_cnt;
        logic sum_end;
        logic at_last;
        logic cnt_lt_min;
        logic x_kept;
        logic mul_done;
        logic div_done;
        logic hit_found;
        logic out_free;
    } t_stat;

endpackage

### src/gorm_mul.sv
// Multi-cycle wide multiplier built on one 32x32 limb product per cycle.
module gorm_mul import gorm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [MUL_AW-1:0] i_a,
    input  logic [MUL_BW-1:0] i_b,
    output logic              o_done,
    output logic [MUL_PW-1:0] o_prod
);

    logic [MUL_AW-1:0]   r_a;
    logic [MUL_BW-1:0]   r_b;
    logic                r_busy;
    logic [1:0]          r_ai;
    logic                r_bi;
    logic [2*MUL_LW-1:0] r_pp;
    logic [1:0]          r_sh;
    logic                r_ppv;
    logic                r_pplast;
    logic [MUL_PW-1:0]   r_acc;
    logic                r_done;
    logic [MUL_LW-1:0]   a_limb;
    logic [MUL_LW-1:0]   b_limb;

    assign a_limb = r_a[MUL_LW*r_ai +: MUL_LW];
    assign b_limb = r_b[MUL_LW*r_bi +: MUL_LW];

    // Latch operands, then issue one limb product per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ppv    <= 1'b0;
            r_pplast <= 1'b0;
            r_ai     <= '0;
            r_bi     <= 1'b0;
        end else if (i_go) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_busy <= 1'b1;
            r_ai   <= '0;
            r_bi   <= 1'b0;
            r_ppv  <= 1'b0;
        end else if (r_busy) begin
            r_pp     <= a_limb * b_limb;
            r_sh     <= 2'(r_ai) + 2'(r_bi);
            r_ppv    <= 1'b1;
            r_pplast <= (r_ai == 2'd2) && r_bi;
            if (r_ai == 2'd2) begin
                r_ai <= '0;
                r_bi <= 1'b1;
                if (r_bi) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_ai <= r_ai + 2'd1;
            end
        end else begin
            r_ppv <= 1'b0;
        end
    end

    // Accumulate shifted partial products
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_acc <= '0;
        end else if (r_ppv) begin
            r_acc <= r_acc + (MUL_PW'(r_pp) << {r_sh, 5'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_ppv && r_pplast && !i_go;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### src/gorm_div.sv
// Restoring divider, one quotient bit per cycle.
module gorm_div #(
    parameter int NW = 38,
    parameter int DW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          qbit;
    logic [DW:0]   diff;

    assign trial = {r_rem, r_num[NW-1]};
    assign qbit  = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    // Shift in one dividend bit and subtract where it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_go) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_cnt  <= KW'(NW);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem  <= qbit ? diff[DW-1:0] : trial[DW-1:0];
            r_num  <= {r_num[NW-2:0], qbit};
            r_cnt  <= r_cnt - KW'(1);
            r_busy <= r_cnt != KW'(1);
            r_done <= r_cnt == KW'(1);
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

### src/gorm_dp.sv
// Datapath: sample store, kept flags, round statistics, outlier test and result register.
module gorm_dp import gorm_pkg::*; #(
    parameter int MAX_SAMPLES  = 20,
    parameter int SAMPLE_WIDTH = 32,
    parameter int XW           = $clog2(MAX_SAMPLES + 2)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [XW-1:0]     i_idx,
    input  logic [CONF_W-1:0] i_row,
    input  t_in_item          i_in_data,
    output t_stat             o_stat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int SW_S = X_W + CW + 1;
    localparam int D_W  = SW_S + 1;

    logic [SAMPLE_WIDTH-1:0]  r_store [MAX_SAMPLES];
    logic [MAX_SAMPLES-1:0]   r_kept;
    logic [CW-1:0]            r_count;
    logic                     r_ovf;

    logic signed [X_W-1:0]    r_p1;
    logic                     r_p1v;
    logic [2*X_W-1:0]         r_p2;
    logic                     r_p2v;
    logic signed [SW_S-1:0]   r_s;
    logic [CW-1:0]            r_nkept;
    logic [Q_W-1:0]           r_q;

    logic [GSQ_W-1:0]         r_g2;
    logic [MUL_PW-1:0]        r_t1;
    logic [MUL_PW-1:0]        r_t2;
    logic [MUL_PW-1:0]        r_thr;
    logic signed [X_W-1:0]    r_x;
    logic                     r_xk;
    logic [D_W-1:0]           r_dmag;
    logic                     r_hit;
    logic [AW-1:0]            r_hidx;
    logic signed [X_W-1:0]    r_hx;
    logic signed [X_W-1:0]    r_avg;
    logic                     r_ovalid;
    t_out_item                r_out;

    logic [AW-1:0]            rd_addr;
    logic signed [SAMPLE_WIDTH-1:0] x_raw;
    logic signed [X_W-1:0]    x_rd;
    logic [X_W-1:0]           p1_mag;
    logic [SW_S-1:0]          s_mag;
    logic [XW-1:0]            cnt_x;
    logic [7:0]               colw;
    logic [4:0]               col;
    logic [G_W-1:0]           g;
    logic signed [D_W-1:0]    cx_a;
    logic signed [D_W-1:0]    cx_b;
    logic signed [D_W-1:0]    cx;
    logic signed [D_W-1:0]    d_val;
    logic [MUL_AW-1:0]        mul_a;
    logic [MUL_BW-1:0]        mul_b;
    logic                     mul_done;
    logic [MUL_PW-1:0]        mul_prod;
    logic                     exceed;
    logic                     div_done;
    logic [SW_S-1:0]          div_quo;

    // Read port of the sample store
    assign rd_addr = i_idx[AW-1:0];
    assign x_raw   = signed'(r_store[rd_addr]);
    assign x_rd    = X_W'(x_raw);

    // Load samples; clear the set after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept  <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.set_clr) begin
            r_kept  <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            if (r_count < CW'(MAX_SAMPLES)) begin
                r_kept[r_count[AW-1:0]] <= 1'b1;
                r_count                 <= r_count + CW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end else if (i_cmd.drop) begin
            r_kept[r_hidx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CW'(MAX_SAMPLES))) begin
            r_store[r_count[AW-1:0]] <= i_in_data.sample[SAMPLE_WIDTH-1:0];
        end
    end

    // Sum pass: sample, then square, then accumulate
    assign p1_mag = r_p1[X_W-1] ? X_W'(-r_p1) : X_W'(r_p1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
        end else begin
            r_p1v <= i_cmd.sum_feed && r_kept[rd_addr];
            r_p2v <= r_p1v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= x_rd;
        r_p2 <= p1_mag * p1_mag;
        if (i_cmd.sum_clr) begin
            r_s     <= '0;
            r_nkept <= '0;
            r_q     <= '0;
        end else begin
            if (r_p1v) begin
                r_s     <= r_s + SW_S'(r_p1);
                r_nkept <= r_nkept + CW'(1);
            end
            if (r_p2v) begin
                r_q <= r_q + Q_W'(r_p2);
            end
        end
    end

    // Critical value squared for the current count
    assign colw = 8'(r_nkept) - 8'(MIN_SAMPLES);
    assign col  = (colw > 8'(CRIT_COLS - 1)) ? 5'(CRIT_COLS - 1) : colw[4:0];
    assign g    = crit_q12(i_row, col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.g2_load) begin
            r_g2 <= g * g;
        end
    end

    // Deviation of one sample: d = n*x - s
    assign s_mag = r_s[SW_S-1] ? SW_S'(-r_s) : SW_S'(r_s);
    assign cx_a  = D_W'($signed({1'b0, r_nkept}));
    assign cx_b  = D_W'(r_x);
    assign cx    = cx_a * cx_b;
    assign d_val = cx - D_W'(r_s);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_sample) begin
            r_x  <= x_rd;
            r_xk <= r_kept[rd_addr];
        end
        if (i_cmd.diff_load) begin
            r_dmag <= d_val[D_W-1] ? D_W'(-d_val) : D_W'(d_val);
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_op)
            OP_QN: begin
                mul_a = MUL_AW'(r_q);
                mul_b = MUL_BW'(r_nkept);
            end
            OP_SS: begin
                mul_a = MUL_AW'(s_mag);
                mul_b = MUL_BW'(s_mag);
            end
            OP_SPN: begin
                mul_a = r_t1[MUL_AW-1:0];
                mul_b = MUL_BW'(r_nkept);
            end
            OP_THR: begin
                mul_a = r_t1[MUL_AW-1:0];
                mul_b = MUL_BW'(r_g2);
            end
            OP_DD: begin
                mul_a = MUL_AW'(r_dmag);
                mul_b = MUL_BW'(r_dmag);
            end
            OP_LHS: begin
                mul_a = r_t2[MUL_AW-1:0];
                mul_b = MUL_BW'(r_nkept - CW'(1));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gorm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign exceed = (mul_prod << LHS_SHIFT) > r_thr;

    // Capture products; track the smallest exceeding sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.hit_clr) begin
            r_hit <= 1'b0;
        end else if (mul_done && (i_cmd.mul_op == OP_LHS) && exceed &&
                     (!r_hit || (r_x < r_hx))) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_done) begin
            unique case (i_cmd.mul_op)
                OP_QN:  r_t1  <= mul_prod;
                OP_SS:  r_t1  <= r_t1 - mul_prod;
                OP_SPN: r_t1  <= mul_prod;
                OP_THR: r_thr <= mul_prod;
                OP_DD:  r_t2  <= mul_prod;
                OP_LHS: begin
                    if (exceed && (!r_hit || (r_x < r_hx))) begin
                        r_hidx <= rd_addr;
                        r_hx   <= r_x;
                    end
                end
                default: ;
            endcase
        end
    end

    // Mean of the kept samples, truncated toward zero
    gorm_div #(
        .NW (SW_S),
        .DW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (s_mag),
        .i_den   (r_nkept),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            if (r_nkept == '0) begin
                r_avg <= '0;
            end else if (r_s[SW_S-1]) begin
                r_avg <= X_W'(-div_quo);
            end else begin
                r_avg <= X_W'(div_quo);
            end
        end
    end

    // Result register toward the output channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.average <= i_cmd.out_ok ? r_avg : '0;
            r_out.ok      <= i_cmd.out_ok;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Status toward the controller
    assign cnt_x = XW'(r_count);

    always_comb begin
        o_stat.set_bad    = r_ovf || (r_count < CW'(MIN_SAMPLES));
        o_stat.idx_lt_cnt = i_idx < cnt_x;
        o_stat.sum_end    = i_idx == (cnt_x + XW'(1));
        o_stat.at_last    = i_idx == (cnt_x - XW'(1));
        o_stat.cnt_lt_min = r_nkept < CW'(MIN_SAMPLES);
        o_stat.x_kept     = r_xk;
        o_stat.mul_done   = mul_done;
        o_stat.div_done   = div_done;
        o_stat.hit_found  = r_hit;
        o_stat.out_free   = !r_ovalid || !i_out_stall;
    end

endmodule

### src/gorm_ctrl.sv
// Controller: sequences loading, rejection rounds, averaging and result hand-off.
module gorm_ctrl import gorm_pkg::*; #(
    parameter int MAX_SAMPLES = 20,
    parameter int XW          = $clog2(MAX_SAMPLES + 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_stall,
    input  t_stat         i_stat,
    output t_cmd          o_cmd,
    output logic [XW-1:0] o_idx
);

    typedef enum logic [14:0] {
        S_LOAD  = 15'h0001,
        S_CHECK = 15'h0002,
        S_SUM   = 15'h0004,
        S_CHK3  = 15'h0008,
        S_QN    = 15'h0010,
        S_SS    = 15'h0020,
        S_SPN   = 15'h0040,
        S_THR   = 15'h0080,
        S_SCAN  = 15'h0100,
        S_DIFF  = 15'h0200,
        S_DD    = 15'h0400,
        S_LHS   = 15'h0800,
        S_DROP  = 15'h1000,
        S_DIV   = 15'h2000,
        S_FIN   = 15'h4000
    } t_state;

    t_state        r_state, n_state;
    logic [XW-1:0] r_idx, n_idx;
    logic          r_ok, n_ok;
    logic          r_go, n_go;
    t_cmd          cmd;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_ok         = r_ok;
        n_go         = 1'b0;
        cmd          = '0;
        cmd.mul_op   = OP_NONE;
        unique case (r_state)
            S_LOAD: begin
                cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.set_bad) begin
                    n_ok    = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_ok    = 1'b1;
                    n_idx   = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                cmd.sum_clr  = r_idx == '0;
                cmd.sum_feed = i_stat.idx_lt_cnt;
                if (i_stat.sum_end) begin
                    n_state = S_CHK3;
                end else begin
                    n_idx = r_idx + XW'(1);
                end
            end
            S_CHK3: begin
                n_go = 1'b1;
                if (i_stat.cnt_lt_min) begin
                    n_state = S_DIV;
                end else begin
                    cmd.g2_load = 1'b1;
                    cmd.hit_clr = 1'b1;
                    n_state     = S_QN;
                end
            end
            S_QN: begin
                cmd.mul_op = OP_QN;
                cmd.mul_go = r_go;
                if (i_stat.mul_done) begin
                    n_go    = 1'b1;
                    n_state = S_SS;
                end
            end
            S_SS: begin
                cmd.mul_op = OP_SS;
                cmd.mul_go = r_go;
                if (i_stat.mul_done) begin
                    n_go    = 1'b1;
                    n_state = S_SPN;
                end
            end
            S_SPN: begin
                cmd.mul_op = OP_SPN;
                cmd.mul_go = r_go;
                if (i_stat.mul_done) begin
                    n_go    = 1'b1;
                    n_state = S_THR;
                end
            end
            S_THR: begin
                cmd.mul_op = OP_THR;
                cmd.mul_go = r_go;
                if (i_stat.mul_done) begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd_sample = 1'b1;
                n_state       = S_DIFF;
            end
            S_DIFF: begin
                if (i_stat.x_kept) begin
                    cmd.diff_load = 1'b1;
                    n_go          = 1'b1;
                    n_state       = S_DD;
                end else if (i_stat.at_last) begin
                    n_state = S_DROP;
                end else begin
                    n_idx   = r_idx + XW'(1);
                    n_state = S_SCAN;
                end
            end
            S_DD: begin
                cmd.mul_op = OP_DD;
                cmd.mul_go = r_go;
                if (i_stat.mul_done) begin
                    n_go    = 1'b1;
                    n_state = S_LHS;
                end
            end
            S_LHS: begin
                cmd.mul_op = OP_LHS;
                cmd.mul_go = r_go;
                if (i_stat.mul_done) begin
                    if (i_stat.at_last) begin
                        n_state = S_DROP;
                    end else begin
                        n_idx   = r_idx + XW'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_DROP: begin
                if (i_stat.hit_found) begin
                    cmd.drop = 1'b1;
                    n_idx    = '0;
                    n_state  = S_SUM;
                end else begin
                    n_go    = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_go = r_go;
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                cmd.out_ok = r_ok;
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.set_clr  = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_ok    <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ok    <= n_ok;
            r_go    <= n_go;
        end
    end

    assign o_cmd      = cmd;
    assign o_idx      = r_idx;
    assign o_in_stall = r_state != S_LOAD;

    // Start pulses last one cycle
    a_go_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |=> !r_go)
        else $error("start pulse held longer than one cycle");

    // A product only arrives while a multiply step waits for it
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mul_done |-> (r_state == S_QN || r_state == S_SS || r_state == S_SPN ||
                             r_state == S_THR || r_state == S_DD || r_state == S_LHS))
        else $error("multiplier finished outside a multiply step");

    // A quotient only arrives while averaging
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> r_state == S_DIV)
        else $error("divider finished outside the averaging step");

    // Handing off a result returns to loading
    a_fin_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && i_stat.out_free) |=> r_state == S_LOAD)
        else $error("result hand-off did not return to loading");

endmodule

### src/grubbs_outlier_reject_mean.sv
// Top level of the Grubbs outlier rejection and mean block.
//
//   channel   direction  handshake               payload
//   in        request    i_in_valid/o_in_stall   i_in_data  (sample, last_sample)
//   out       result     o_out_valid/i_out_stall o_out_data (average, ok)
//   cfg       write      i_cfg_wr_en             i_cfg_wr_data (confidence_level)
//
// Samples load at one per cycle while o_in_stall is low; the sample with last_sample set ends the set.
// Each rejection round is paced by the limb multiplier, which forms two wide products per kept
// sample; averaging runs in the bit-serial divider, and a failed set goes straight to the result.
// Reset is synchronous, active low; no clearing pass is needed after reset.
// A result waits in the output register while a stalled out channel holds it.
module grubbs_outlier_reject_mean import gorm_pkg::*; #(
    parameter int MAX_SAMPLES  = 20,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic [CONF_W-1:0] i_cfg_wr_data
);

    localparam int XW = $clog2(MAX_SAMPLES + 2);

    logic [CONF_W-1:0] r_conf;
    t_cmd              cmd;
    t_stat             stat;
    logic [XW-1:0]     idx;

    // Confidence level register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf <= CONF_RESET;
        end else if (i_cfg_wr_en) begin
            r_conf <= i_cfg_wr_data;
        end
    end

    gorm_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .XW          (XW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_sample),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    gorm_dp #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .XW           (XW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_row       (r_conf),
        .i_in_data   (i_in_data),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
